/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every edge
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/buhs_pkg.sv */
// ----------------------------------------------------------------------------
// buhs_pkg
// Fixed port field widths of the bottom-up heap sorter.
// ----------------------------------------------------------------------------
package buhs_pkg;

	localparam int FIELD_W = 32;

	typedef logic [FIELD_W-1:0] field_t;

endpackage

/* rtl/bottom_up_heap_sorter_core.sv */
// ----------------------------------------------------------------------------
// bottom_up_heap_sorter_core
// Collects records into a heap store, sorts them with bottom-up heapsort and
// streams them out in ascending key order.
// ----------------------------------------------------------------------------
// Load: one word per cycle. Build: each interior node is read, then sifted down one
// level at a time. Pop: the path of larger children is walked down to a leaf, then
// the displaced record climbs back up; the store is read, compared and written back
// one heap level at a time. Emit: one word per cycle once the first word is read,
// stalls with out_ready.
// Reset (arst_n low, async): empty set, unsigned compare, no output pending; store kept.
module bottom_up_heap_sorter_core #(
	parameter int MAX_RECORDS = 64,
	parameter int KEY_WIDTH   = 32,
	parameter int TAG_WIDTH   = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  buhs_pkg::field_t       key,
	input  buhs_pkg::field_t       tag,
	input  logic                   last_in,
	output logic                   out_valid,
	input  logic                   out_ready,
	output buhs_pkg::field_t       sorted_key,
	output buhs_pkg::field_t       sorted_tag,
	output logic                   last_out,
	output logic                   overflow
);

	localparam int FW = buhs_pkg::FIELD_W;
	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam int AW = $clog2(MAX_RECORDS);
	localparam int RW = KEY_WIDTH + TAG_WIDTH;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);
	localparam logic [CW-1:0] ONE     = CW'(1);
	localparam logic [CW-1:0] TWO     = CW'(2);
	localparam logic [CW-1:0] THREE   = CW'(3);

	typedef enum logic [3:0] {
		S_LOAD,
		S_BLD_L,
		S_BLD_TOP,
		S_BLD_SIFT,
		S_BLD_PUT,
		S_POP,
		S_POP_TOP,
		S_POP_DOWN,
		S_UP_RD,
		S_UP_CMP,
		S_EMIT_RD,
		S_EMIT_OUT
	} state_t;

	function automatic logic key_less(input logic [KEY_WIDTH-1:0] a,
		input logic [KEY_WIDTH-1:0] b, input logic sgn);
		logic [KEY_WIDTH-1:0] flip;
		flip = {sgn, {(KEY_WIDTH-1){1'b0}}};
		return (a ^ flip) < (b ^ flip);
	endfunction

	// heap index is 1-based, store address 0-based
	function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] idx);
		logic [CW-1:0] t;
		t = idx - ONE;
		return t[AW-1:0];
	endfunction

	state_t          state_q;
	logic            ksgn_q;
	logic [CW-1:0]   cnt_q;
	logic            drop_q;
	logic [CW-1:0]   l_q;
	logic [CW-1:0]   m_q;
	logic [CW-1:0]   up_q;
	logic [CW-1:0]   child_q;
	logic [CW-1:0]   idx_q;
	logic [RW-1:0]   cur_q;
	logic            out_valid_q;
	logic [FW-1:0]   out_key_q;
	logic [FW-1:0]   out_tag_q;
	logic            out_last_q;
	logic            out_ovf_q;

	logic [RW-1:0]   rd_a;
	logic [RW-1:0]   rd_b;
	logic [KEY_WIDTH-1:0] key_a;
	logic [KEY_WIDTH-1:0] key_b;
	logic [KEY_WIDTH-1:0] key_c;
	logic            in_acc;
	logic            has_room;
	logic [CW-1:0]   n_new;
	logic            has_b;
	logic            take_b;
	logic [RW-1:0]   big;
	logic [CW-1:0]   sel;
	logic [CW:0]     nchild;
	logic            ngo;
	logic            cur_lt_big;
	logic            disp_lt;
	logic [CW-1:0]   l2;
	logic [CW-1:0]   idx_nx;
	logic            emit_load;
	logic [CW-1:0]   ra_idx;
	logic [CW-1:0]   rb_idx;
	logic            mem_we;
	logic [CW-1:0]   wa_idx;
	logic [RW-1:0]   wd;

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == S_LOAD);
	assign in_acc     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign sorted_key = out_key_q;
	assign sorted_tag = out_tag_q;
	assign last_out   = out_last_q;
	assign overflow   = out_ovf_q;

	assign key_a = rd_a[RW-1:TAG_WIDTH];
	assign key_b = rd_b[RW-1:TAG_WIDTH];
	assign key_c = cur_q[RW-1:TAG_WIDTH];

	assign has_room = (cnt_q < MAX_CNT);
	assign n_new    = cnt_q + CW'(has_room);

	// larger child of child_q / child_q+1, then compare against the moving record
	assign has_b      = (child_q < m_q);
	assign take_b     = has_b && key_less(key_a, key_b, ksgn_q);
	assign big        = take_b ? rd_b : rd_a;
	assign sel        = child_q + CW'(take_b);
	assign nchild     = {sel, 1'b0};
	assign ngo        = (nchild <= {1'b0, m_q});
	assign cur_lt_big = take_b ? key_less(key_c, key_b, ksgn_q) : key_less(key_c, key_a, ksgn_q);
	assign disp_lt    = key_less(key_c, key_a, ksgn_q);
	assign l2         = {l_q[CW-2:0], 1'b0};
	assign idx_nx     = idx_q + ONE;
	assign emit_load  = (state_q == S_EMIT_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		ra_idx = idx_q;
		rb_idx = ONE;
		mem_we = 1'b0;
		wa_idx = up_q;
		wd     = cur_q;
		case (state_q)
			S_LOAD: begin
				mem_we = in_acc && has_room;
				wa_idx = cnt_q + ONE;
				wd     = {key[KEY_WIDTH-1:0], tag[TAG_WIDTH-1:0]};
			end
			S_BLD_L: begin
				ra_idx = l_q;
			end
			S_BLD_TOP: begin
				ra_idx = l2;
				rb_idx = l2 + ONE;
			end
			S_BLD_SIFT: begin
				ra_idx = nchild[CW-1:0];
				rb_idx = nchild[CW-1:0] + ONE;
				mem_we = 1'b1;
				wd     = cur_lt_big ? big : cur_q;
			end
			S_BLD_PUT: begin
				mem_we = 1'b1;
			end
			S_POP: begin
				ra_idx = m_q;
				rb_idx = ONE;
			end
			S_POP_TOP: begin
				ra_idx = TWO;
				rb_idx = THREE;
				mem_we = 1'b1;
				wa_idx = m_q;
				wd     = rd_b;
			end
			S_POP_DOWN: begin
				ra_idx = nchild[CW-1:0];
				rb_idx = nchild[CW-1:0] + ONE;
				mem_we = 1'b1;
				wd     = big;
			end
			S_UP_RD: begin
				ra_idx = {1'b0, up_q[CW-1:1]};
				mem_we = (up_q == ONE);
			end
			S_UP_CMP: begin
				mem_we = 1'b1;
				wd     = disp_lt ? cur_q : rd_a;
			end
			S_EMIT_RD: begin
				ra_idx = idx_q;
			end
			S_EMIT_OUT: begin
				ra_idx = emit_load ? idx_nx : idx_q;
			end
			default: begin
				ra_idx = idx_q;
			end
		endcase
	end

	buhs_ram #(
		.DEPTH (MAX_RECORDS),
		.AW    (AW),
		.DW    (RW)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (addr_of(wa_idx)),
		.wdata   (wd),
		.raddr_a (addr_of(ra_idx)),
		.raddr_b (addr_of(rb_idx)),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksgn_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			ksgn_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			l_q         <= '0;
			m_q         <= '0;
			up_q        <= '0;
			child_q     <= '0;
			idx_q       <= '0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
			out_key_q   <= '0;
			out_tag_q   <= '0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						cnt_q <= n_new;
						if (!has_room) begin
							drop_q <= 1'b1;
						end
						if (last_in) begin
							m_q     <= n_new;
							l_q     <= {1'b0, n_new[CW-1:1]};
							state_q <= S_BLD_L;
						end
					end
				end
				S_BLD_L: begin
					state_q <= (l_q == '0) ? S_POP : S_BLD_TOP;
				end
				S_BLD_TOP: begin
					cur_q   <= rd_a;
					up_q    <= l_q;
					child_q <= l2;
					state_q <= S_BLD_SIFT;
				end
				S_BLD_SIFT: begin
					if (!cur_lt_big) begin
						l_q     <= l_q - ONE;
						state_q <= S_BLD_L;
					end else begin
						up_q <= sel;
						if (ngo) begin
							child_q <= nchild[CW-1:0];
						end else begin
							state_q <= S_BLD_PUT;
						end
					end
				end
				S_BLD_PUT: begin
					l_q     <= l_q - ONE;
					state_q <= S_BLD_L;
				end
				S_POP: begin
					if (m_q <= ONE) begin
						idx_q   <= ONE;
						state_q <= S_EMIT_RD;
					end else begin
						state_q <= S_POP_TOP;
					end
				end
				S_POP_TOP: begin
					// last record becomes the displaced one, top goes to the end
					cur_q   <= rd_a;
					m_q     <= m_q - ONE;
					up_q    <= ONE;
					child_q <= TWO;
					state_q <= (m_q >= THREE) ? S_POP_DOWN : S_UP_RD;
				end
				S_POP_DOWN: begin
					up_q <= sel;
					if (ngo) begin
						child_q <= nchild[CW-1:0];
					end else begin
						state_q <= S_UP_RD;
					end
				end
				S_UP_RD: begin
					state_q <= (up_q == ONE) ? S_POP : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (disp_lt) begin
						state_q <= S_POP;
					end else begin
						up_q    <= {1'b0, up_q[CW-1:1]};
						state_q <= S_UP_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_OUT;
				end
				S_EMIT_OUT: begin
					if (emit_load) begin
						out_key_q   <= FW'(rd_a[RW-1:TAG_WIDTH]);
						out_tag_q   <= FW'(rd_a[TAG_WIDTH-1:0]);
						out_last_q  <= (idx_q == cnt_q);
						out_ovf_q   <= drop_q;
						if (idx_q == cnt_q) begin
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							idx_q <= idx_nx;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_cnt_cap, cnt_q <= MAX_CNT, "record count beyond capacity")
	`ASSERT_IMPLY(a_heap_in_set, state_q != S_LOAD, m_q <= cnt_q, "heap size exceeds record count")
	`ASSERT_IMPLY(a_wr_range, mem_we, (wa_idx != '0) && (wa_idx <= MAX_CNT), "store write outside heap")
	`ASSERT_NEXT(a_last_starts, in_acc && last_in, !in_ready, "input still taken after set closed")

endmodule

/* rtl/buhs_ram.sv */
// ----------------------------------------------------------------------------
// buhs_ram
// Heap record store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module buhs_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [DW-1:0] rdata_a,
	output logic [DW-1:0] rdata_b
);

	logic [DW-1:0] mem_q [DEPTH];

	// read returns the old word on a same-address write; the sequencer never relies on it
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule
